>>> hw/rtl/tlwc_pkg.sv
// Shared types, constants and small lookup functions for the traffic light
// controller with walk countdown. No dependencies.

package tlwc_pkg;

  // Register map of the configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PHASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_PHASE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_STEP  = 2'd2;

  localparam logic [15:0] LONG_PHASE_RST  = 16'd8000;
  localparam logic [15:0] SHORT_PHASE_RST = 16'd2000;
  localparam logic [15:0] COUNT_STEP_RST  = 16'd1000;

  // Beat widths
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 16;

  // Lamp bits
  localparam int unsigned LAMP_RED    = 0;
  localparam int unsigned LAMP_YELLOW = 1;
  localparam int unsigned LAMP_GREEN  = 2;
  localparam int unsigned LAMP_WHITE  = 3;

  localparam logic [6:0] SEG_ALL    = 7'h7F;
  localparam logic [3:0] DIGIT_RST  = 4'd9;
  localparam logic [3:0] DIGIT_ZERO = 4'd0;
  localparam logic [3:0] DIGIT_STOP = 4'd8;

  // Phase codes as shown on the result beat
  localparam logic [2:0] PHASE_CODE_START  = 3'd0;
  localparam logic [2:0] PHASE_CODE_RED    = 3'd1;
  localparam logic [2:0] PHASE_CODE_REDYEL = 3'd2;
  localparam logic [2:0] PHASE_CODE_GREEN  = 3'd3;
  localparam logic [2:0] PHASE_CODE_YELLOW = 3'd4;

  typedef enum logic [4:0] {
    PH_START  = 5'b00001,
    PH_RED    = 5'b00010,
    PH_REDYEL = 5'b00100,
    PH_GREEN  = 5'b01000,
    PH_YELLOW = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [15:0] long_phase_ticks;
    logic [15:0] short_phase_ticks;
    logic [15:0] count_step_ticks;
  } cfg_t;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] phase_count;
    logic        walk_request;
    logic [3:0]  lamps;
    logic        count_running;
    logic [15:0] count_ticks;
    logic [3:0]  digit;
    logic [6:0]  segments;
  } state_t;

  function automatic logic [2:0] phase_code(input phase_t ph);
    logic [2:0] code;
    unique case (ph)
      PH_START:  code = PHASE_CODE_START;
      PH_RED:    code = PHASE_CODE_RED;
      PH_REDYEL: code = PHASE_CODE_REDYEL;
      PH_GREEN:  code = PHASE_CODE_GREEN;
      PH_YELLOW: code = PHASE_CODE_YELLOW;
      default:   code = PHASE_CODE_START;
    endcase
    return code;
  endfunction

  // (digit + 8) mod 9 over the whole 4-bit range
  function automatic logic [3:0] digit_dec(input logic [3:0] d);
    logic [4:0] s;
    s = {1'b0, d} + 5'd8;
    if (s >= 5'd18) begin
      s = s - 5'd18;
    end else if (s >= 5'd9) begin
      s = s - 5'd9;
    end
    return s[3:0];
  endfunction

  function automatic logic [6:0] glyph(input logic [3:0] d);
    logic [6:0] g;
    unique case (d)
      4'd0:    g = 7'h7E;
      4'd1:    g = 7'h30;
      4'd2:    g = 7'h6D;
      4'd3:    g = 7'h79;
      4'd4:    g = 7'h33;
      4'd5:    g = 7'h5B;
      4'd6:    g = 7'h1F;
      4'd7:    g = 7'h70;
      4'd8:    g = 7'h7F;
      default: g = SEG_ALL;
    endcase
    return g;
  endfunction

endpackage

>>> hw/rtl/traffic_light_with_walk_countdown_unit.sv
// Top level of the traffic light controller with walk countdown.
// Depends on tlwc_pkg and tlwc_next.

// Usage:
//   in_*   : one beat per millisecond slot; in_tdata[0] is the tick flag,
//            in_tdata[1] the pedestrian button rising edge.
//   out_*  : one result beat per input beat, showing lamps, the seven-segment
//            pattern and the phase code after that beat's update.
//   cfg_*  : write port for the three dwell registers (long phase, short
//            phase, countdown step); write only while no beat is in flight.
// A result becomes valid in the cycle after its input is accepted. Throughput
// is one beat per cycle while the receiver takes results: the state update is
// a single pass of next-state logic into the state and result registers.
// When the receiver stalls, the result register holds its beat and
// in_tready drops until that beat is taken or leaves in the same cycle.
// Reset (synchronous, active low) loads the dwell registers with their
// defaults, puts the lights in the start phase with all lamps off, the
// display on all segments, the digit at nine and empties the result register.

module traffic_light_with_walk_countdown_unit import tlwc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [0] tick, [1] button_rise, rest zero
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [0] red_lamp, [1] yellow_lamp, [2] green_lamp, [3] white_lamp,
  // [10:4] segments, [13:11] phase, rest zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t   cfg_r;
  state_t state_r, state_nxt;
  logic   out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic   in_fire;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  tlwc_next u_next (
    .cur         (state_r),
    .cfg         (cfg_r),
    .tick        (in_tdata[0]),
    .button_rise (in_tdata[1]),
    .nxt         (state_nxt)
  );

  assign out_data_nxt = {2'b00, phase_code(state_nxt.phase), state_nxt.segments,
                         state_nxt.lamps};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_phase_ticks  <= LONG_PHASE_RST;
      cfg_r.short_phase_ticks <= SHORT_PHASE_RST;
      cfg_r.count_step_ticks  <= COUNT_STEP_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_LONG_PHASE:  cfg_r.long_phase_ticks  <= cfg_wdata;
        CFG_SHORT_PHASE: cfg_r.short_phase_ticks <= cfg_wdata;
        CFG_COUNT_STEP:  cfg_r.count_step_ticks  <= cfg_wdata;
        default: ;  // drop writes past the register map
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase         <= PH_START;
      state_r.phase_count   <= '0;
      state_r.walk_request  <= 1'b0;
      state_r.lamps         <= '0;
      state_r.count_running <= 1'b0;
      state_r.count_ticks   <= '0;
      state_r.digit         <= DIGIT_RST;
      state_r.segments      <= SEG_ALL;
      out_valid_r           <= 1'b0;
    end else begin
      if (in_fire) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, loaded on each accepted beat
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

>>> hw/rtl/tlwc_next.sv
// Next-state logic for one input beat: walk toggle, countdown step, then
// phase step. Depends on tlwc_pkg.

module tlwc_next import tlwc_pkg::*; (
  input  state_t cur,
  input  cfg_t   cfg,
  input  logic   tick,
  input  logic   button_rise,
  output state_t nxt
);

  logic [15:0] ct_inc;
  logic [15:0] pc_inc;
  logic [15:0] dwell;
  logic [3:0]  dig_dec;

  always_comb begin
    nxt          = cur;
    ct_inc       = cur.count_ticks + 16'd1;
    pc_inc       = cur.phase_count + 16'd1;
    dig_dec      = digit_dec(cur.digit);
    dwell        = ((cur.phase == PH_RED) || (cur.phase == PH_GREEN)) ?
                   cfg.long_phase_ticks : cfg.short_phase_ticks;

    nxt.walk_request = cur.walk_request ^ button_rise;

    if (tick) begin
      // countdown advances first
      if (cur.count_running) begin
        nxt.count_ticks = ct_inc;
        if (ct_inc >= cfg.count_step_ticks) begin
          nxt.count_ticks = '0;
          if (dig_dec == DIGIT_ZERO) begin
            nxt.count_running = 1'b0;
            nxt.digit         = DIGIT_STOP;
            nxt.segments      = SEG_ALL;
          end else begin
            nxt.digit    = dig_dec;
            nxt.segments = glyph(dig_dec);
          end
        end
      end

      nxt.phase_count = pc_inc;
      if (pc_inc >= dwell) begin
        nxt.phase_count = '0;
        unique case (cur.phase)
          PH_START, PH_YELLOW: begin
            nxt.phase = PH_RED;
            nxt.lamps = 4'b0001;
            if (nxt.walk_request) begin
              if (!nxt.count_running) begin
                nxt.count_running = 1'b1;
                nxt.count_ticks   = '0;
              end
              nxt.lamps[LAMP_WHITE] = 1'b1;
              nxt.walk_request      = 1'b0;
            end
          end
          PH_RED: begin
            nxt.phase = PH_REDYEL;
            nxt.lamps = '0;
            nxt.lamps[LAMP_RED]    = 1'b1;
            nxt.lamps[LAMP_YELLOW] = 1'b1;
          end
          PH_REDYEL: begin
            nxt.phase = PH_GREEN;
            nxt.lamps = '0;
            nxt.lamps[LAMP_GREEN] = 1'b1;
          end
          PH_GREEN: begin
            nxt.phase = PH_YELLOW;
            nxt.lamps = '0;
            nxt.lamps[LAMP_YELLOW] = 1'b1;
          end
          default: begin
            nxt.phase = PH_RED;
            nxt.lamps = 4'b0001;
          end
        endcase
      end
    end
  end

endmodule

>>> hw/rtl/tlwc_checker.sv
// Port-level checks for the traffic light controller, bound to the top level.
// Depends on tlwc_pkg.

module tlwc_checker import tlwc_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // empty result register never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty result register");

  // every accepted beat yields a result next cycle
  a_accept_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted beat produced no result");

  // green phase lights green, with red and yellow dark
  a_green_lamps: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[13:11] == PHASE_CODE_GREEN) |->
      out_tdata[LAMP_GREEN] && !out_tdata[LAMP_RED] && !out_tdata[LAMP_YELLOW])
    else $error("lamps disagree with green phase");

  // start phase keeps every lamp dark and the display full
  a_start_dark: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[13:11] == PHASE_CODE_START) |->
      (out_tdata[3:0] == 4'b0000) && (out_tdata[10:4] == SEG_ALL))
    else $error("lamps or display active in start phase");

endmodule

bind traffic_light_with_walk_countdown_unit tlwc_checker u_tlwc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

>>> dv/traffic_light_with_walk_countdown_unit_tb.sv
// Self-checking bench for the traffic light controller with walk countdown.
// A lamp and countdown predictor checks every result beat; needs tlwc_pkg and the unit.
`timescale 1ns / 100ps

module traffic_light_with_walk_countdown_unit_tb;
  import tlwc_pkg::*;

  typedef struct packed {
    logic [2:0] phase;
    logic [6:0] segments;
    logic       white;
    logic       green;
    logic       yellow;
    logic       red;
  } light_beat_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // [0] tick, [1] button_rise
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // [0] red, [1] yellow, [2] green, [3] white, [10:4] segments, [13:11] phase
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  traffic_light_with_walk_countdown_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Predicted controller state and its copy of the dwell registers
  logic [15:0] long_ticks, short_ticks, step_ticks;
  logic [2:0]  cur_phase;
  logic [15:0] phase_ticks;
  logic        walk_pending;
  logic [3:0]  lamp_bits;
  logic        countdown_on;
  logic [15:0] countdown_ticks;
  logic [3:0]  shown_digit;
  logic [6:0]  seg_bits;

  // Patterns for digits 0..8, bit6 = a down to bit0 = g
  logic [6:0] digit_pattern [0:8] = '{7'h7E, 7'h30, 7'h6D, 7'h79, 7'h33,
                                      7'h5B, 7'h1F, 7'h70, 7'h7F};

  logic [1:0]    slot_q[$];     // {button_rise, tick} waiting to go out
  light_beat_t   lights_q[$];   // predicted result beats, oldest first
  light_beat_t   want;
  int unsigned   beats_sent = 0;
  int unsigned   beats_seen = 0;
  int unsigned   mismatches = 0;
  int unsigned   send_idle_pct = 7;
  int unsigned   recv_idle_pct = 71;
  logic          rx_hold_kick = 1'b0;
  logic [15:0]   rx_hold_left = '0;

  function automatic light_beat_t advance_lights(input logic tick, input logic press);
    light_beat_t b;
    logic [15:0] dwell;
    if (press) walk_pending = ~walk_pending;
    if (tick) begin
      // countdown moves before the phase logic
      if (countdown_on) begin
        countdown_ticks = countdown_ticks + 16'd1;
        if (countdown_ticks >= step_ticks) begin
          countdown_ticks = '0;
          shown_digit = shown_digit - 4'd1;
          if (shown_digit == DIGIT_ZERO) begin
            countdown_on = 1'b0;
            shown_digit = DIGIT_STOP;
            seg_bits = SEG_ALL;
          end else begin
            seg_bits = digit_pattern[shown_digit];
          end
        end
      end
      dwell = (cur_phase == PHASE_CODE_RED || cur_phase == PHASE_CODE_GREEN) ?
              long_ticks : short_ticks;
      phase_ticks = phase_ticks + 16'd1;
      if (phase_ticks >= dwell) begin
        phase_ticks = '0;
        lamp_bits = '0;
        case (cur_phase)
          PHASE_CODE_RED: begin
            cur_phase = PHASE_CODE_REDYEL;
            lamp_bits[LAMP_RED] = 1'b1;
            lamp_bits[LAMP_YELLOW] = 1'b1;
          end
          PHASE_CODE_REDYEL: begin
            cur_phase = PHASE_CODE_GREEN;
            lamp_bits[LAMP_GREEN] = 1'b1;
          end
          PHASE_CODE_GREEN: begin
            cur_phase = PHASE_CODE_YELLOW;
            lamp_bits[LAMP_YELLOW] = 1'b1;
          end
          default: begin
            cur_phase = PHASE_CODE_RED;
            lamp_bits[LAMP_RED] = 1'b1;
            if (walk_pending) begin
              // a running countdown carries on untouched
              if (!countdown_on) begin
                countdown_on = 1'b1;
                countdown_ticks = '0;
              end
              lamp_bits[LAMP_WHITE] = 1'b1;
              walk_pending = 1'b0;
            end
          end
        endcase
      end
    end
    b.red      = lamp_bits[LAMP_RED];
    b.yellow   = lamp_bits[LAMP_YELLOW];
    b.green    = lamp_bits[LAMP_GREEN];
    b.white    = lamp_bits[LAMP_WHITE];
    b.segments = seg_bits;
    b.phase    = cur_phase;
    return b;
  endfunction

  task automatic check_field(input string what, input int unsigned exp_v,
                             input int unsigned got_v);
    if (exp_v != got_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on result beat %0d: %s expected 0x%0h, got 0x%0h",
                 beats_seen, what, exp_v, got_v);
    end
  endtask

  // Sender: offer queued slots, idling at random
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
    end else if (!in_tvalid || in_tready) begin
      if (slot_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata <= {{(IN_DATA_W-2){1'b0}}, slot_q.pop_front()};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Predict on every accepted input beat
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      lights_q.push_back(advance_lights(in_tdata[0], in_tdata[1]));
  end

  // Long receiver hold-off, counted here
  always @(posedge clk) begin
    if (!rst_n) begin
      rx_hold_left <= '0;
    end else if (rx_hold_kick) begin
      rx_hold_left <= 16'd250;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 16'd1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= (rx_hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each accepted result beat against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (lights_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result beat %0d arrived with nothing predicted: 0x%0h",
                   beats_seen, out_tdata);
      end else begin
        want = lights_q.pop_front();
        check_field("red_lamp", want.red, out_tdata[0]);
        check_field("yellow_lamp", want.yellow, out_tdata[1]);
        check_field("green_lamp", want.green, out_tdata[2]);
        check_field("white_lamp", want.white, out_tdata[3]);
        check_field("segments", want.segments, out_tdata[10:4]);
        check_field("phase", want.phase, out_tdata[13:11]);
      end
      beats_seen <= beats_seen + 1;
    end
  end

  task automatic send_slot(input logic press, input logic tick);
    slot_q.push_back({press, tick});
    beats_sent++;
  endtask

  // Hold until every sent beat has come back, then let the pipe settle
  task automatic drain;
    while (beats_seen != beats_sent) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_LONG_PHASE:  long_ticks = val;
      CFG_SHORT_PHASE: short_ticks = val;
      default:         step_ticks = val;
    endcase
  endtask

  task automatic set_dwells(input logic [15:0] lng, input logic [15:0] sht,
                            input logic [15:0] stp);
    write_reg(CFG_LONG_PHASE, lng);
    write_reg(CFG_SHORT_PHASE, sht);
    write_reg(CFG_COUNT_STEP, stp);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(input logic [15:0] lng, input logic [15:0] sht,
                            input logic [15:0] stp, input int unsigned n,
                            input int unsigned tx_idle, input int unsigned rx_idle,
                            input bit hold_rx);
    set_dwells(lng, sht, stp);
    send_idle_pct = tx_idle;
    recv_idle_pct = rx_idle;
    // mostly ticks, with sparse button edges and some empty slots
    for (int unsigned i = 0; i < n; i++)
      send_slot($urandom_range(99) < 8, $urandom_range(99) < 88);
    if (hold_rx) begin
      @(posedge clk);
      rx_hold_kick <= 1'b1;
      @(posedge clk);
      rx_hold_kick <= 1'b0;
    end
    drain();
  endtask

  logic [1:0] walk_script [0:16] = '{2'b10, 2'b01, 2'b01, 2'b11, 2'b01, 2'b01,
                                     2'b01, 2'b01, 2'b01, 2'b01, 2'b01, 2'b11,
                                     2'b01, 2'b01, 2'b01, 2'b01, 2'b01};

  initial begin
    long_ticks = LONG_PHASE_RST;
    short_ticks = SHORT_PHASE_RST;
    step_ticks = COUNT_STEP_RST;
    cur_phase = PHASE_CODE_START;
    phase_ticks = '0;
    walk_pending = 1'b0;
    lamp_bits = '0;
    countdown_on = 1'b0;
    countdown_ticks = '0;
    shown_digit = DIGIT_RST;
    seg_bits = SEG_ALL;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset dwell values: empty slots, lone edges, edge with tick
    send_slot(1'b0, 1'b0);
    send_slot(1'b1, 1'b0);
    send_slot(1'b1, 1'b1);
    send_slot(1'b0, 1'b1);
    send_slot(1'b0, 1'b0);
    send_slot(1'b1, 1'b1);
    drain();

    // One-tick phases and steps: red entry with and without a running countdown,
    // countdown running out and restarting from eight
    set_dwells(16'd1, 16'd1, 16'd1);
    foreach (walk_script[i])
      send_slot(walk_script[i][1], walk_script[i][0]);
    drain();

    run_random(16'd5, 16'd2, 16'd3, 300, 7, 71, 1'b0);
    run_random(16'hFFFF, 16'hFFFF, 16'hFFFF, 40, 7, 71, 1'b0);
    // dwell cut below the elapsed count: phase ends on the next tick
    run_random(16'd2, 16'd1, 16'd1, 300, 7, 71, 1'b0);
    run_random(16'd7, 16'd3, 16'd2, 300, 71, 7, 1'b0);
    run_random(16'd1, 16'd4, 16'd5, 300, 71, 7, 1'b0);
    run_random(16'd9, 16'd2, 16'd1, 300, 0, 0, 1'b0);
    run_random(16'd4, 16'd2, 16'hFFFF, 150, 0, 0, 1'b0);
    run_random(16'd6, 16'd1, 16'd2, 260, 0, 0, 1'b1);

    if (mismatches == 0 && lights_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/tlwc_pkg.sv
hw/rtl/tlwc_next.sv
hw/rtl/traffic_light_with_walk_countdown_unit.sv
hw/rtl/tlwc_checker.sv
dv/traffic_light_with_walk_countdown_unit_tb.sv
